// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

	// bitmap word geometry: one RAM word holds WORD_BITS block bits
	localparam int WORD_BITS = 32;
	localparam int WORD_SH   = 5;

	// width of the block number and count fields on the ports
	localparam int FIELD_W = 14;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_SH-1:0]   wpos_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_RANGE = 2'd2,
		ERR_FREE  = 2'd3
	} err_t;

	// position of the lowest clear bit; zero when the word is all ones
	function automatic wpos_t low_zero(input word_t w);
		wpos_t r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = wpos_t'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/block_bitmap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit block allocator over a used/free bitmap held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser[0] is the op (0 allocate, 1 free), tdata
//   holds the one-based block number to free. m_axis returns one result per
//   request: granted number, error code and the remaining free count.
//   cfg_valid/cfg_data write total_blocks; write it only while the block idles.
// Operation:
//   The bitmap sits in a data RAM of 32-bit words. A summary RAM keeps one
//   "word full" bit per data word, 32 to an entry. An allocate reads summary
//   entries in order until one shows a non-full word, then reads and updates
//   that data word. A free reads the data word and its summary entry
//   together. A range error goes to the result without a RAM read. The next
//   request transfer is taken in the cycle after the result is loaded.
// Reset:
//   arst_n starts a clearing pass that zeroes one data word per cycle;
//   no request transfer is taken until it ends. Configuration writes are
//   taken at any time.
// Stalls:
//   The result sits in an output register; the next request is accepted while
//   it waits, but its own result holds until the receiver takes the first.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator_unit
	import bba_pkg::*;
#(
	parameter int MAP_BITS = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [13:0] block_number, [15:14] zero
	input  wire logic [0:0]  s_axis_tuser,  // [0] op
	// result channel
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // [13:0] granted_number,
	                                        // [27:14] free_count, [31:28] zero
	output logic      [1:0]  m_axis_tuser,  // [1:0] error
	// configuration: total_blocks
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [13:0] cfg_data
);

	// geometry
	localparam int D     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int S     = (D + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (D > 1) ? $clog2(D) : 1;
	localparam int SAW   = (S > 1) ? $clog2(S) : 1;
	localparam int LIM_W = $clog2(MAP_BITS + 1);
	localparam int NW    = (LIM_W > FIELD_W) ? LIM_W : FIELD_W;
	localparam int CW    = (SAW + 2 * WORD_SH > NW) ? SAW + 2 * WORD_SH : NW;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_SRD   = 9'b000000100,
		ST_SCHK  = 9'b000001000,
		ST_DRD   = 9'b000010000,
		ST_DCHK  = 9'b000100000,
		ST_FRD   = 9'b001000000,
		ST_FCHK  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [13:0]       total_q;
	logic [NW-1:0]     used_q;
	logic [SAW-1:0]    sidx_q;
	wpos_t             spos_q;
	wpos_t             bit_q;
	logic [AW-1:0]     word_q;
	word_t             srd_q;
	logic [13:0]       res_grant_q;
	err_t              res_err_q;

	logic              out_valid_q;
	logic [13:0]       out_grant_q;
	err_t              out_err_q;
	logic [13:0]       out_free_q;

	// RAM ports
	logic              d_we;
	logic [AW-1:0]     d_waddr;
	word_t             d_wdata;
	word_t             d_rdata;
	logic              s_we;
	logic [SAW-1:0]    s_waddr;
	word_t             s_wdata;
	word_t             s_rdata;

	// effective total, saturated to the map size
	logic [NW-1:0]     total_ext;
	logic [NW-1:0]     lim;
	logic [CW-1:0]     lim_c;
	logic [NW-1:0]     num_ext;
	logic [CW-1:0]     fidx;
	logic              in_xfer;
	logic              res_load;

	// scan and update helpers
	wpos_t             s_pos;
	logic [CW-1:0]     s_word;
	wpos_t             d_pos;
	logic [CW-1:0]     d_idx;
	word_t             d_set;
	logic [CW-1:0]     grant_c;
	logic [NW-1:0]     free_n;

	assign total_ext = NW'(total_q);
	assign lim       = (total_ext > NW'(MAP_BITS)) ? NW'(MAP_BITS) : total_ext;
	assign lim_c     = CW'(lim);
	assign num_ext   = NW'(s_axis_tdata[13:0]);
	assign fidx      = CW'(num_ext) - CW'(1);
	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	// a finished result moves into the output register once that is free
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign s_pos   = low_zero(s_rdata);
	assign s_word  = CW'({sidx_q, s_pos});
	assign d_pos   = low_zero(d_rdata);
	assign d_idx   = (CW'(word_q) << WORD_SH) | CW'(d_pos);
	assign d_set   = d_rdata | (word_t'(1) << d_pos);
	assign grant_c = d_idx + CW'(1);
	assign free_n  = (lim > used_q) ? (lim - used_q) : '0;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_free_q, out_grant_q};
	assign m_axis_tuser  = out_err_q;

	// RAM write side
	always_comb begin
		d_we    = 1'b0;
		d_waddr = word_q;
		d_wdata = '0;
		s_we    = 1'b0;
		s_waddr = sidx_q;
		s_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				d_we    = 1'b1;
				d_waddr = clr_q;
				s_we    = (CW'(clr_q) < CW'(S));
				s_waddr = clr_q[SAW-1:0];
			end
			ST_DCHK: begin
				if (d_idx < lim_c) begin
					d_we    = 1'b1;
					d_wdata = d_set;
					// mark the word full in its summary entry
					s_we    = &d_set;
					s_wdata = srd_q | (word_t'(1) << spos_q);
				end
			end
			ST_FCHK: begin
				if (d_rdata[bit_q]) begin
					d_we    = 1'b1;
					d_wdata = d_rdata & ~(word_t'(1) << bit_q);
					s_we    = 1'b1;
					s_wdata = s_rdata & ~(word_t'(1) << spos_q);
				end
			end
			default: begin
			end
		endcase
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (D)
	) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (word_q),
		.rdata (d_rdata)
	);

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (S)
	) u_summary_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (sidx_q),
		.rdata (s_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 14'd8192;
		end else if (cfg_valid) begin
			total_q <= cfg_data;
		end
	end

	// output register valid: set on a load, drop once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(D - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						res_grant_q <= '0;
						if (!s_axis_tuser[0]) begin
							sidx_q  <= '0;
							state_q <= ST_SRD;
						end else if (num_ext == '0 || num_ext > lim) begin
							res_err_q <= ERR_RANGE;
							state_q   <= ST_DONE;
						end else begin
							word_q  <= fidx[AW+WORD_SH-1:WORD_SH];
							bit_q   <= fidx[WORD_SH-1:0];
							sidx_q  <= fidx[SAW+2*WORD_SH-1:2*WORD_SH];
							spos_q  <= fidx[2*WORD_SH-1:WORD_SH];
							state_q <= ST_FRD;
						end
					end
				end
				ST_SRD: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					if (&s_rdata) begin
						// every word of this entry is full: advance or give up
						if (sidx_q == SAW'(S - 1)) begin
							res_err_q <= ERR_FULL;
							state_q   <= ST_DONE;
						end else begin
							sidx_q  <= sidx_q + SAW'(1);
							state_q <= ST_SRD;
						end
					end else if ((s_word << WORD_SH) >= lim_c) begin
						res_err_q <= ERR_FULL;
						state_q   <= ST_DONE;
					end else begin
						spos_q  <= s_pos;
						srd_q   <= s_rdata;
						word_q  <= s_word[AW-1:0];
						state_q <= ST_DRD;
					end
				end
				ST_DRD: begin
					state_q <= ST_DCHK;
				end
				ST_DCHK: begin
					if (d_idx >= lim_c) begin
						res_err_q <= ERR_FULL;
					end else begin
						res_err_q   <= ERR_OK;
						res_grant_q <= grant_c[13:0];
						used_q      <= used_q + NW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_FRD: begin
					state_q <= ST_FCHK;
				end
				ST_FCHK: begin
					if (!d_rdata[bit_q]) begin
						res_err_q <= ERR_FREE;
					end else begin
						res_err_q <= ERR_OK;
						if (used_q != '0) begin
							used_q <= used_q - NW'(1);
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (res_load) begin
						out_grant_q <= res_grant_q;
						out_err_q   <= res_err_q;
						out_free_q  <= free_n[13:0];
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block bitmap allocator.
// ----------------------------------------------------------------------------
// A table of directed requests and register writes runs first: range errors
// at both ends of the block number, double frees, the first grants, and the
// totals of zero, one and above the map. Random phases follow under several
// totals. One phase fills more than a thousand blocks so that the scan has to
// step over full summary words. Another shrinks the total below the used
// region. A predictor kept in the bench mirrors the bitmap and the used count
// and yields the expected result of every accepted request. The monitor checks
// each result transfer, field by field, against the oldest expectation.
// The sender works in bursts. The receiver stalls on its own pattern and holds
// off once for a long stretch, so the request side backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import bba_pkg::*;

	localparam int MAP_BITS     = 8192;
	localparam int MAX_NUMBER   = (1 << FIELD_W) - 1;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int N_ROWS       = 26;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		ROW_REQ = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	typedef struct packed {
		logic [FIELD_W-1:0] granted;
		err_t               err;
		logic [FIELD_W-1:0] free_left;
	} alloc_result_t;

	typedef struct packed {
		row_kind_t          kind;
		op_t                op;
		logic [FIELD_W-1:0] value;   // block number, or total for a register row
		logic               typed;   // want holds a result read off by hand
		alloc_result_t      want;
	} stim_row_t;

	// directed requests, starting from the reset total of 8192
	stim_row_t directed_rows [N_ROWS] = '{
		'{ROW_REQ, OP_FREE,  14'd0,     1'b1, '{14'd0, ERR_RANGE, 14'd8192}},
		'{ROW_REQ, OP_FREE,  14'd8193,  1'b1, '{14'd0, ERR_RANGE, 14'd8192}},
		'{ROW_REQ, OP_FREE,  14'd16383, 1'b1, '{14'd0, ERR_RANGE, 14'd8192}},
		'{ROW_REQ, OP_FREE,  14'd1,     1'b1, '{14'd0, ERR_FREE,  14'd8192}},
		'{ROW_REQ, OP_FREE,  14'd8192,  1'b1, '{14'd0, ERR_FREE,  14'd8192}},
		'{ROW_REQ, OP_ALLOC, 14'd0,     1'b1, '{14'd1, ERR_OK,    14'd8191}},
		'{ROW_REQ, OP_ALLOC, 14'd16383, 1'b1, '{14'd2, ERR_OK,    14'd8190}},
		'{ROW_REQ, OP_ALLOC, 14'd0,     1'b1, '{14'd3, ERR_OK,    14'd8189}},
		'{ROW_REQ, OP_FREE,  14'd2,     1'b1, '{14'd0, ERR_OK,    14'd8190}},
		'{ROW_REQ, OP_FREE,  14'd2,     1'b1, '{14'd0, ERR_FREE,  14'd8190}},
		'{ROW_REQ, OP_ALLOC, 14'd5,     1'b0, '0},
		// total of one: three blocks used, so the free count saturates at zero
		'{ROW_CFG, OP_ALLOC, 14'd1,     1'b0, '0},
		'{ROW_REQ, OP_ALLOC, 14'd0,     1'b1, '{14'd0, ERR_FULL,  14'd0}},
		'{ROW_REQ, OP_FREE,  14'd2,     1'b1, '{14'd0, ERR_RANGE, 14'd0}},
		'{ROW_REQ, OP_FREE,  14'd1,     1'b1, '{14'd0, ERR_OK,    14'd0}},
		'{ROW_REQ, OP_ALLOC, 14'd0,     1'b0, '0},
		// total of zero: nothing takes part
		'{ROW_CFG, OP_ALLOC, 14'd0,     1'b0, '0},
		'{ROW_REQ, OP_ALLOC, 14'd0,     1'b1, '{14'd0, ERR_FULL,  14'd0}},
		'{ROW_REQ, OP_FREE,  14'd1,     1'b1, '{14'd0, ERR_RANGE, 14'd0}},
		// above the map: saturates to the full map
		'{ROW_CFG, OP_ALLOC, 14'd16383, 1'b0, '0},
		'{ROW_REQ, OP_FREE,  14'd8193,  1'b1, '{14'd0, ERR_RANGE, 14'd8189}},
		'{ROW_REQ, OP_FREE,  14'd1,     1'b0, '0},
		'{ROW_REQ, OP_FREE,  14'd2,     1'b0, '0},
		'{ROW_REQ, OP_FREE,  14'd3,     1'b0, '0},
		'{ROW_REQ, OP_ALLOC, 14'd0,     1'b1, '{14'd1, ERR_OK,    14'd8191}},
		'{ROW_REQ, OP_FREE,  14'd1,     1'b1, '{14'd0, ERR_OK,    14'd8192}}
	};

	// block inputs, all driven to known values from time zero
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [13:0] cfg_data      = '0;

	// predictor state: a mirror of the bitmap, the used count and the register
	bit                 block_used [MAP_BITS];
	int                 used_blocks = 0;
	logic [FIELD_W-1:0] total_reg   = 14'd8192;

	alloc_result_t awaited_results [$];

	// sender burst state
	int burst_left = 0;

	// hold-off requests to the receiver: a new ticket starts one long stall
	int hold_ticket = 0;

	// run statistics
	int fail_cnt    = 0;
	int cycle_cnt   = 0;
	int n_requests  = 0;
	int n_results   = 0;
	int n_granted   = 0;
	int n_full      = 0;
	int n_range     = 0;
	int n_dup_free  = 0;
	int n_cfg       = 0;

	block_bitmap_allocator_unit #(
		.MAP_BITS(MAP_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [13:0] block_number, [15:14] zero
		.s_axis_tuser  (s_axis_tuser),   // [0] op
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [13:0] granted_number, [27:14] free_count
		.m_axis_tuser  (m_axis_tuser),   // [1:0] error
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// totals above the map saturate to the map size
	function automatic int active_total();
		return (int'(total_reg) > MAP_BITS) ? MAP_BITS : int'(total_reg);
	endfunction

	// apply one request to the mirrored bitmap and return its result
	function automatic alloc_result_t apply_alloc_request(input op_t op,
			input logic [FIELD_W-1:0] number);
		alloc_result_t r;
		int lim;
		int idx;
		lim = active_total();
		r = '0;
		r.err = ERR_OK;
		if (op == OP_ALLOC) begin
			// first fit: lowest clear bit below the total
			idx = 0;
			while (idx < lim && block_used[idx]) begin
				idx++;
			end
			if (idx < lim) begin
				block_used[idx] = 1'b1;
				used_blocks++;
				r.granted = FIELD_W'(idx + 1);
			end else begin
				r.err = ERR_FULL;
			end
		end else begin
			if (number == 0 || int'(number) > lim) begin
				r.err = ERR_RANGE;
			end else if (!block_used[int'(number) - 1]) begin
				r.err = ERR_FREE;
			end else begin
				block_used[int'(number) - 1] = 1'b0;
				if (used_blocks > 0) begin
					used_blocks--;
				end
			end
		end
		// blocks used above a shrunk total still count, so clamp at zero
		r.free_left = FIELD_W'((lim > used_blocks) ? lim - used_blocks : 0);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// request side: called at a falling edge, returns at a falling edge
	// ------------------------------------------------------------------------

	task automatic send_request(input op_t op, input logic [FIELD_W-1:0] number,
			input logic typed, input alloc_result_t typed_want);
		int gap;
		alloc_result_t predicted;
		// start a new burst, mostly after a random gap
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, number};
		s_axis_tuser  <= op;
		// hold the request until the block takes it
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		predicted = apply_alloc_request(op, number);
		awaited_results.push_back(typed ? typed_want : predicted);
		n_requests++;
		@(negedge clk);
	endtask

	// register write, only once every expected result has been taken
	task automatic write_total_blocks(input logic [FIELD_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		total_reg = value;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		burst_left = 0;
	endtask

	// random requests; frees mostly aim at numbers up to num_hi, the rest at
	// zero, at the edge of the total, or anywhere in the field
	task automatic run_random_phase(input int n_items, input int alloc_pct,
			input int num_hi, input int hold_at);
		op_t op;
		logic [FIELD_W-1:0] number;
		int pick;
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at) begin
				hold_ticket++;
			end
			op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
			pick = $urandom_range(0, 99);
			if (op == OP_ALLOC) begin
				// the number is ignored on allocate; drive junk anyway
				number = FIELD_W'($urandom_range(0, MAX_NUMBER));
			end else if (pick < 75) begin
				number = FIELD_W'($urandom_range(1, num_hi));
			end else if (pick < 82) begin
				number = '0;
			end else if (pick < 90) begin
				number = FIELD_W'(active_total() + $urandom_range(0, 1));
			end else begin
				number = FIELD_W'($urandom_range(0, MAX_NUMBER));
			end
			send_request(op, number, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------------
	// result side: own stall pattern, plus one long hold-off when asked
	// ------------------------------------------------------------------------

	int rx_cyc    = 0;
	int hold_left = 0;
	int hold_seen = 0;

	always @(negedge clk) begin
		rx_cyc++;
		if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			// rotate through ready modes on a period unrelated to the sender
			case ((rx_cyc / 173) % 4)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				2: m_axis_tready <= ((rx_cyc % 7) < 4);
				default: m_axis_tready <= ($urandom_range(0, 99) < 85);
			endcase
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.granted   = m_axis_tdata[FIELD_W-1:0];
			got.free_left = m_axis_tdata[2*FIELD_W-1:FIELD_W];
			got.err       = err_t'(m_axis_tuser);
			n_results++;
			case (got.err)
				ERR_OK:    n_granted += (got.granted != 0) ? 1 : 0;
				ERR_FULL:  n_full++;
				ERR_RANGE: n_range++;
				default:   n_dup_free++;
			endcase
			if (awaited_results.size() == 0) begin
				fail_cnt++;
				$display("%0t: result with nothing expected: granted %0d err %0d free %0d",
					$realtime, got.granted, got.err, got.free_left);
			end else begin
				want = awaited_results.pop_front();
				if (got != want) begin
					fail_cnt++;
					if (fail_cnt <= 20) begin
						$display("%0t: mismatch expected granted %0d err %0d free %0d, %s",
							$realtime, want.granted, want.err, want.free_left,
							$sformatf("actual granted %0d err %0d free %0d",
								got.granted, got.err, got.free_left));
					end
				end
			end
		end
	end

	// generous cap on the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table; register rows wait for the block to go idle
		for (int i = 0; i < N_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_total_blocks(directed_rows[i].value);
			end else begin
				send_request(directed_rows[i].op, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// fill past one full summary word so the scan skips entries; the
		// receiver holds off early on so the request side backs up
		write_total_blocks(14'd8192);
		run_random_phase(1150, 97, 1300, 200);

		// shrink below the used region: out-of-range frees, clamped count
		write_total_blocks(14'd40);
		run_random_phase(150, 50, 48, -1);

		write_total_blocks(14'd0);
		run_random_phase(20, 50, 4, -1);

		write_total_blocks(14'd1);
		run_random_phase(30, 50, 2, -1);

		// full map again: heavy freeing reopens low holes
		write_total_blocks(14'd16383);
		run_random_phase(200, 40, 1400, -1);

		write_total_blocks(14'd100);
		run_random_phase(80, 60, 110, -1);

		// drain, then give stray results time to show up
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (50) @(posedge clk);

		$display("Covered %0d requests and %0d results under %0d register writes.",
			n_requests, n_results, n_cfg);
		$display("Grants %0d, full %0d, out of range %0d, double free %0d.",
			n_granted, n_full, n_range, n_dup_free);
		if (fail_cnt == 0 && awaited_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
